@@ rtl/postfix_expression_evaluator_top_defines.svh @@
// Assertion macros used by the evaluator top level.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define PFE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pfe_pkg.sv @@
`default_nettype none

package pfe_pkg;

   localparam int CharW             = 8;
   localparam int ValueW            = 32;
   localparam int StatusW           = 2;
   localparam int RspDataW          = 40;
   localparam int RspPadW           = RspDataW - ValueW - StatusW;
   localparam int StackDepthDefault = 64;

   localparam logic [CharW-1:0] ChZero  = 8'h30;
   localparam logic [CharW-1:0] ChNine  = 8'h39;
   localparam logic [CharW-1:0] ChPlus  = 8'h2B;
   localparam logic [CharW-1:0] ChMinus = 8'h2D;
   localparam logic [CharW-1:0] ChStar  = 8'h2A;
   localparam logic [CharW-1:0] ChSlash = 8'h2F;

   localparam logic [StatusW-1:0] StOk        = 2'd0;
   localparam logic [StatusW-1:0] StUnderflow = 2'd1;
   localparam logic [StatusW-1:0] StDivZero   = 2'd2;
   localparam logic [StatusW-1:0] StOverflow  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic               accept;
      logic               push;
      logic               set_err;
      logic [StatusW-1:0] err_code;
      logic               start_op;
      logic               alu_write;
      logic               div_start;
      logic               div_write;
      logic               emit;
   } pfe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_digit;
      logic in_op;
      logic in_div;
      logic in_final;
      logic stack_full;
      logic stack_low;
      logic tos_zero;
      logic err_set;
      logic op_div;
      logic last;
      logic div_done;
      logic out_free;
   } pfe_stat_type;

endpackage

`default_nettype wire

@@ rtl/postfix_expression_evaluator_top.sv @@
// Postfix expression evaluator.
// req channel: one character per item, req_tdata[7:0] the ASCII code, req_tlast
// set on the last character of an expression. Digits push 0..9; + - * / pop two
// entries and push (second popped) op (first popped), 32-bit wraparound, division
// truncating toward zero. Any other character is ignored.
// rsp channel: one item per expression, rsp_tdata[31:0] the top of the stack
// (0 on error), rsp_tdata[33:32] the status: 0 ok, 1 underflow, 2 divide by
// zero, 3 overflow. The first error of an expression is kept.
// A digit or an ignored character is taken in the idle state; + - * go through
// a read state for the registered RAM port and an execute state, and / also
// through the bit-per-cycle divider. The last character passes through the emit
// state, which loads the result register.
// Reset empties the stack and clears the error. No clearing pass is needed.
// A result waits in the output register while rsp_tready is low; characters
// keep being accepted, and only the next result waits for the register to free.
`default_nettype none
`include "postfix_expression_evaluator_top_defines.svh"

module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = pfe_pkg::StackDepthDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [pfe_pkg::CharW-1:0]    req_tdata,  // [7:0] char_code
   input  wire logic                         req_tlast,  // final_char
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [pfe_pkg::RspDataW-1:0] rsp_tdata   // [31:0] value, [33:32] status
);
   import pfe_pkg::*;

   pfe_cmd_type        cmd;
   pfe_stat_type       stat;
   logic [ValueW-1:0]  rsp_value;
   logic [StatusW-1:0] rsp_status;

   pfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfe_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_char   (req_tdata),
      .req_final  (req_tlast),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {RspPadW'(0), rsp_status, rsp_value};

   `PFE_ASSERT_IMP(a_push_room, clock, reset, cmd.push, !stat.stack_full, "push on full stack")
   `PFE_ASSERT_IMP(a_div_done, clock, reset, cmd.div_write, stat.div_done, "quotient taken early")
   `PFE_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_tvalid, "result not presented")
   `PFE_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && (rsp_status != StOk), rsp_value == '0, "nonzero value on error")

endmodule

`default_nettype wire

@@ rtl/pfe_ram.sv @@
`default_nettype none

module pfe_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/pfe_div.sv @@
`default_nettype none

module pfe_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pfe_pkg::ValueW-1:0] dividend,
   input  wire logic [pfe_pkg::ValueW-1:0] divisor,
   output logic                           done,
   output logic      [pfe_pkg::ValueW-1:0] quotient
);
   import pfe_pkg::*;

   localparam int CntW = $clog2(ValueW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ValueW-1:0] rem_ff, rem_in;
   logic [ValueW-1:0] quo_ff, quo_in;
   logic [ValueW-1:0] ud_ff, ud_in;
   logic              neg_ff, neg_in;
   logic [ValueW:0]   shifted;
   logic [ValueW:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[ValueW-1]};
      diff    = shifted - {1'b0, ud_ff};
      if (start) begin
         // work on magnitudes, fix the sign at the end
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[ValueW-1] ? (ValueW'(0) - dividend) : dividend;
         ud_in   = divisor[ValueW-1] ? (ValueW'(0) - divisor) : divisor;
         neg_in  = dividend[ValueW-1] ^ divisor[ValueW-1];
      end else if (busy_ff) begin
         if (!diff[ValueW]) begin
            rem_in = diff[ValueW-1:0];
         end else begin
            rem_in = shifted[ValueW-1:0];
         end
         quo_in = {quo_ff[ValueW-2:0], ~diff[ValueW]};
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(ValueW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ud_ff  <= ud_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (ValueW'(0) - quo_ff) : quo_ff;

endmodule

`default_nettype wire

@@ rtl/pfe_ctrl.sv @@
`default_nettype none

module pfe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire pfe_pkg::pfe_stat_type stat,
   output pfe_pkg::pfe_cmd_type       cmd
);
   import pfe_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_DIV  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = stat.in_final ? S_EMIT : S_IDLE;
               priority if (stat.err_set) begin
                  // sticky error: drop the item
               end else if (stat.in_digit) begin
                  if (stat.stack_full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = StOverflow;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end else if (stat.in_op) begin
                  if (stat.stack_low) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = StUnderflow;
                  end else if (stat.in_div && stat.tos_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = StDivZero;
                  end else begin
                     cmd.start_op = 1'b1;
                     state_in     = S_READ;
                  end
               end else begin
                  // other characters leave the stack alone
               end
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.op_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.alu_write = 1'b1;
               state_in      = stat.last ? S_EMIT : S_IDLE;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_write = 1'b1;
               state_in      = stat.last ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pfe_dp.sv @@
`default_nettype none

module pfe_dp #(
   parameter int STACK_DEPTH = pfe_pkg::StackDepthDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [pfe_pkg::CharW-1:0]   req_char,
   input  wire logic                        req_final,
   input  wire pfe_pkg::pfe_cmd_type        cmd,
   output pfe_pkg::pfe_stat_type            stat,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [pfe_pkg::ValueW-1:0]  rsp_value,
   output logic      [pfe_pkg::StatusW-1:0] rsp_status
);
   import pfe_pkg::*;

   localparam int AddrW  = $clog2(STACK_DEPTH);
   localparam int DepthW = $clog2(STACK_DEPTH + 1);

   logic [DepthW-1:0]  depth_ff, depth_in;
   logic [StatusW-1:0] err_ff, err_in;
   logic [ValueW-1:0]  tos_ff, tos_in;
   logic [CharW-1:0]   op_ff, op_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   logic [ValueW-1:0]  out_value_ff, out_value_in;
   logic [StatusW-1:0] out_status_ff, out_status_in;

   logic [ValueW-1:0]  digit_val;
   logic [ValueW-1:0]  below;
   logic [ValueW-1:0]  alu_res;
   logic [ValueW-1:0]  quot;
   logic               div_done;
   logic               ram_we;
   logic [AddrW-1:0]   ram_waddr;
   logic [ValueW-1:0]  ram_wdata;
   logic [DepthW-1:0]  depth_m2;

   assign digit_val = ValueW'(req_char - ChZero);
   assign depth_m2  = depth_ff - DepthW'(2);

   always_comb begin
      unique case (op_ff)
         ChPlus:  alu_res = below + tos_ff;
         ChMinus: alu_res = below - tos_ff;
         ChStar:  alu_res = below * tos_ff;
         default: alu_res = below + tos_ff;
      endcase
   end

   pfe_ram #(
      .Width (ValueW),
      .Depth (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.start_op),
      .rd_addr (depth_m2[AddrW-1:0]),
      .rd_data (below)
   );

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (below),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      ram_we    = cmd.push || cmd.alu_write || cmd.div_write;
      ram_waddr = cmd.push ? depth_ff[AddrW-1:0] : depth_m2[AddrW-1:0];
      ram_wdata = cmd.push ? digit_val : (cmd.div_write ? quot : alu_res);

      depth_in      = depth_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      if (cmd.accept) begin
         op_in   = req_char;
         last_in = req_final;
      end
      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end
      if (cmd.push) begin
         tos_in   = digit_val;
         depth_in = depth_ff + DepthW'(1);
      end
      if (cmd.alu_write || cmd.div_write) begin
         tos_in   = ram_wdata;
         depth_in = depth_ff - DepthW'(1);
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (err_ff != StOk) begin
            out_status_in = err_ff;
            out_value_in  = '0;
         end else if (depth_ff == '0) begin
            out_status_in = StUnderflow;
            out_value_in  = '0;
         end else begin
            out_status_in = StOk;
            out_value_in  = tos_ff;
         end
         // start the next expression on an empty stack
         depth_in = '0;
         err_in   = StOk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= StOk;
         out_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
      end
      tos_ff        <= tos_in;
      op_ff         <= op_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      stat.in_digit   = (req_char >= ChZero) && (req_char <= ChNine);
      stat.in_op      = (req_char == ChPlus) || (req_char == ChMinus) ||
                        (req_char == ChStar) || (req_char == ChSlash);
      stat.in_div     = (req_char == ChSlash);
      stat.in_final   = req_final;
      stat.stack_full = (depth_ff == DepthW'(STACK_DEPTH));
      stat.stack_low  = (depth_ff < DepthW'(2));
      stat.tos_zero   = (tos_ff == '0);
      stat.err_set    = (err_ff != StOk);
      stat.op_div     = (op_ff == ChSlash);
      stat.last       = last_ff;
      stat.div_done   = div_done;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

endmodule

`default_nettype wire
